@@ src/fwsr_pkg.sv @@
// Shared action codes and cell control type for the search-and-remove queue.
package fwsr_pkg;

	localparam logic [2:0] ACT_ENQUEUE = 3'd0;
	localparam logic [2:0] ACT_DEQUEUE = 3'd1;
	localparam logic [2:0] ACT_SEARCH  = 3'd2;
	localparam logic [2:0] ACT_REWIND  = 3'd3;
	localparam logic [2:0] ACT_NEXT    = 3'd4;
	localparam logic [2:0] ACT_REMOVE  = 3'd5;

	// per-cell control signals
	typedef struct packed {
		logic load;   // take the incoming value
		logic shift;  // take the neighbor's value (gap closing)
	} cell_ctrl_t;

endpackage

@@ src/fwsr_cell.sv @@
// One storage cell of the queue: holds an entry, shifts from its neighbor, compares.
module fwsr_cell import fwsr_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [VALUE_BITS-1:0] din,
	input  logic [VALUE_BITS-1:0] neighbor,
	output logic [VALUE_BITS-1:0] value,
	output logic                  match
);

	logic [VALUE_BITS-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= din;
		end else if (ctrl.shift) begin
			value_q <= neighbor;
		end
	end

	assign value = value_q;
	assign match = (value_q == din);

endmodule

@@ src/fifo_with_search_and_remove_core.sv @@
// Top level of the ordered queue with search, cursor walk and remove.
//
// Usage:
//  - Input channel: in_valid / in_stall carry one operation (action, item_value).
//    Actions: enqueue, dequeue, search, rewind, next, remove last returned.
//  - Output channel: out_valid / out_stall carry one result per operation
//    (ok, item_out, fill_count, is_empty), in operation order.
//  - The operation is captured in a stage register, then executed against
//    the row of cells and the result written to the output register.
//  - Throughput: one operation per cycle while the output is taken.
//  - Entries live in a row of DEPTH cells, head in cell 0. A deletion makes
//    every cell behind the gap take its neighbor's value together.
//    Search compares all cells in parallel and ORs the hits below the count.
//  - Reset clears the count, the cursor marks and both valid flags; cell
//    contents are left as they are and are never read before being written.
//  - When out_stall is high the result holds; the staged operation waits, and
//    in_stall rises once the stage register is occupied.
module fifo_with_search_and_remove_core import fwsr_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [2:0]                           action,
	input  logic [VALUE_BITS-1:0]                item_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 ok,
	output logic [VALUE_BITS-1:0]                item_out,
	output logic [$clog2(DEPTH+1)-1:0]           fill_count,
	output logic                                 is_empty
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] NONE  = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] ZERO  = '0;

	// Mark adjustment once the entry at gone has left; cnt_new is the count after.
	function automatic logic [CNT_W-1:0] follow(input logic [CNT_W-1:0] mark,
	                                            input logic [CNT_W-1:0] gone,
	                                            input logic [CNT_W-1:0] cnt_new);
		logic [CNT_W-1:0] r;
		if (mark >= NONE) begin
			r = NONE;
		end else if (mark > gone) begin
			r = mark - ONE;
		end else if (mark == gone) begin
			r = (gone < cnt_new) ? mark : NONE;
		end else begin
			r = mark;
		end
		return r;
	endfunction

	// stage register
	logic                  valid_s1;
	logic [2:0]            action_s1;
	logic [VALUE_BITS-1:0] value_s1;

	// queue state
	logic [CNT_W-1:0] count_q, cursor_q, saved_q, last_q;

	// output register
	logic                  out_valid_q, ok_q, is_empty_q;
	logic [VALUE_BITS-1:0] item_q;
	logic [CNT_W-1:0]      fill_q;

	logic exec_fire, in_accept;

	assign exec_fire = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !exec_fire;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (exec_fire || !valid_s1) begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1 <= action;
			value_s1  <= item_value;
		end
	end

	// cell row
	logic [VALUE_BITS-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0]      cell_match;
	logic [DEPTH-1:0]      cell_live;
	cell_ctrl_t            cell_ctrl  [DEPTH];

	logic             do_load, do_shift;
	logic [CNT_W-1:0] shift_pos;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_BITS-1:0] nb;
		if (i == DEPTH - 1) begin : g_last
			assign nb = cell_value[i];
		end else begin : g_mid
			assign nb = cell_value[i + 1];
		end
		assign cell_live[i]       = (CNT_W'(i) < count_q);
		assign cell_ctrl[i].load  = exec_fire && do_load && (CNT_W'(i) == count_q);
		assign cell_ctrl[i].shift = exec_fire && do_shift && (CNT_W'(i) >= shift_pos)
		                            && (CNT_W'(i + 1) < count_q);
		fwsr_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.din      (value_s1),
			.neighbor (nb),
			.value    (cell_value[i]),
			.match    (cell_match[i])
		);
	end

	// execute
	logic [CNT_W-1:0]      count_d, cursor_d, saved_d, last_d;
	logic                  ok_d;
	logic [VALUE_BITS-1:0] item_d;
	logic                  cursor_ok;

	assign cursor_ok = (cursor_q < count_q) && (cursor_q < NONE);

	always_comb begin
		count_d   = count_q;
		cursor_d  = cursor_q;
		saved_d   = saved_q;
		last_d    = last_q;
		ok_d      = 1'b0;
		item_d    = '0;
		do_load   = 1'b0;
		do_shift  = 1'b0;
		shift_pos = ZERO;
		unique case (action_s1)
			ACT_ENQUEUE: begin
				if (count_q < NONE) begin
					do_load = 1'b1;
					if (count_q == ZERO) begin
						cursor_d = ZERO;
					end
					count_d = count_q + ONE;
					ok_d    = 1'b1;
				end
			end
			ACT_DEQUEUE: begin
				if (count_q != ZERO) begin
					item_d    = cell_value[0];
					do_shift  = 1'b1;
					count_d   = count_q - ONE;
					last_d    = (last_q == ZERO) ? NONE : follow(last_q, ZERO, count_d);
					cursor_d  = follow(cursor_q, ZERO, count_d);
					saved_d   = follow(saved_q, ZERO, count_d);
					ok_d      = 1'b1;
				end
			end
			ACT_SEARCH: begin
				ok_d = |(cell_match & cell_live);
			end
			ACT_REWIND: begin
				saved_d  = cursor_q;
				cursor_d = (count_q != ZERO) ? ZERO : NONE;
				last_d   = NONE;
				ok_d     = 1'b1;
			end
			ACT_NEXT: begin
				if (!cursor_ok) begin
					cursor_d = (saved_q < count_q) ? saved_q : NONE;
				end else begin
					item_d   = cell_value[cursor_q[IDX_W-1:0]];
					last_d   = cursor_q;
					cursor_d = ((cursor_q + ONE) < count_q) ? cursor_q + ONE : NONE;
					ok_d     = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if ((last_q < count_q) && (last_q < NONE)) begin
					do_shift  = 1'b1;
					shift_pos = last_q;
					count_d   = count_q - ONE;
					saved_d   = follow(saved_q, last_q, count_d);
					cursor_d  = NONE;
					last_d    = NONE;
					ok_d      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= ZERO;
			cursor_q <= NONE;
			saved_q  <= NONE;
			last_q   <= NONE;
		end else if (exec_fire) begin
			count_q  <= count_d;
			cursor_q <= cursor_d;
			saved_q  <= saved_d;
			last_q   <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			ok_q       <= ok_d;
			item_q     <= item_d;
			fill_q     <= count_d;
			is_empty_q <= (count_d == ZERO);
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign item_out   = item_q;
	assign fill_count = fill_q;
	assign is_empty   = is_empty_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NONE)
		else $error("count above depth");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q == NONE) || (cursor_q < count_q))
		else $error("cursor points past the entries");

	a_last_range: assert property (@(posedge clk) disable iff (!arst_n)
		(last_q == NONE) || (last_q < count_q))
		else $error("last-returned mark points past the entries");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (is_empty_q == (fill_q == ZERO)))
		else $error("empty flag disagrees with fill count");

	a_dequeue_count: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && action_s1 == ACT_DEQUEUE && count_q != ZERO)
		|=> (count_q == $past(count_q) - ONE))
		else $error("dequeue did not drop the count");

endmodule

@@ tb/fifo_with_search_and_remove_core_tb.sv @@
// Testbench for the search-and-remove queue: directed and random operations against a shadow queue.
module fifo_with_search_and_remove_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fwsr_pkg::*;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam logic [4:0] MARK_NONE = 5'd16;   // "no entry" code for all cursor marks
	localparam logic [2:0] ACT_SPARE_LO = 3'd6; // unused action codes, must be ignored
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;
	localparam int IDLE_LIMIT = 2000;            // cycles with no transfer before giving up
	localparam int TAIL_CYCLES = 8;              // settle time after the last result

	typedef struct {
		logic        ok;
		logic [31:0] item;
		logic [4:0]  fill;
		logic        empty;
	} queue_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [2:0]            action;
	logic [VALUE_BITS-1:0] item_value;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  ok;
	logic [VALUE_BITS-1:0] item_out;
	logic [4:0]            fill_count;
	logic                  is_empty;

	// shadow copy of the queue and its marks
	logic [31:0] ent [DEPTH];
	logic [4:0]  ent_count;
	logic [4:0]  walk_pos;
	logic [4:0]  walk_saved;
	logic [4:0]  last_taken;

	queue_result_t pending_results [$];

	int errors;
	int n_sent;
	int n_checked;
	int n_full_refused;
	int n_search_hits;
	int n_removed;
	int n_walk_end;
	bit idle_off;      // when set, neither side inserts gaps or stalls
	int stall_left;
	int idle_cycles;

	fifo_with_search_and_remove_core #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.item_out(item_out),
		.fill_count(fill_count),
		.is_empty(is_empty)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Shadow queue
	// ---------------------------------------------------------------------

	// Re-aim a mark after the entry at 'gone' left; ent_count is already reduced.
	// A mark on the gone entry slides to its successor, or clears if none.
	function automatic logic [4:0] track_mark(logic [4:0] mark, logic [4:0] gone);
		if (mark >= MARK_NONE)
			return MARK_NONE;
		if (mark > gone)
			return mark - 5'd1;
		if (mark == gone)
			return (gone < ent_count) ? mark : MARK_NONE;
		return mark;
	endfunction

	function automatic void close_gap(int pos);
		for (int i = pos; i + 1 < ent_count; i++)
			ent[i] = ent[i + 1];
		ent_count = ent_count - 5'd1;
	endfunction

	function automatic queue_result_t apply_queue_op(logic [2:0] act, logic [31:0] val);
		queue_result_t r;
		logic [4:0] gone;
		r.ok = 1'b0;
		r.item = '0;
		case (act)
			ACT_ENQUEUE: begin
				if (ent_count < DEPTH) begin
					ent[ent_count] = val;
					if (ent_count == 0)
						walk_pos = 5'd0;   // first entry pulls the cursor onto the head
					ent_count = ent_count + 5'd1;
					r.ok = 1'b1;
				end else begin
					n_full_refused++;
				end
			end
			ACT_DEQUEUE: begin
				if (ent_count > 0) begin
					r.item = ent[0];
					close_gap(0);
					// popping the entry last returned voids the remove target
					last_taken = (last_taken == 0) ? MARK_NONE : track_mark(last_taken, 5'd0);
					walk_pos   = track_mark(walk_pos, 5'd0);
					walk_saved = track_mark(walk_saved, 5'd0);
					r.ok = 1'b1;
				end
			end
			ACT_SEARCH: begin
				for (int i = 0; i < ent_count; i++)
					if (ent[i] == val)
						r.ok = 1'b1;
				if (r.ok)
					n_search_hits++;
			end
			ACT_REWIND: begin
				walk_saved = walk_pos;
				walk_pos   = (ent_count > 0) ? 5'd0 : MARK_NONE;
				last_taken = MARK_NONE;
				r.ok = 1'b1;
			end
			ACT_NEXT: begin
				if (walk_pos >= ent_count) begin
					// end of walk: fall back to the saved cursor if it still exists
					walk_pos = (walk_saved < ent_count) ? walk_saved : MARK_NONE;
					n_walk_end++;
				end else begin
					r.item = ent[walk_pos];
					last_taken = walk_pos;
					walk_pos = (int'(walk_pos) + 1 < ent_count) ? walk_pos + 5'd1 : MARK_NONE;
					r.ok = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (last_taken < ent_count) begin
					gone = last_taken;
					close_gap(gone);
					walk_saved = track_mark(walk_saved, gone);
					walk_pos   = MARK_NONE;
					last_taken = MARK_NONE;
					r.ok = 1'b1;
					n_removed++;
				end
			end
			default: ;
		endcase
		r.fill  = ent_count;
		r.empty = (ent_count == 0);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (idle_off)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// mix of full-range values, small values (duplicates) and values near all-ones
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return $urandom_range(0, 7);
		if (r < 20)
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
		return $urandom;
	endfunction

	// search key: half the time a value known to be in the queue
	function automatic logic [31:0] pick_key();
		if (ent_count > 0 && $urandom_range(0, 1) == 0)
			return ent[$urandom_range(0, ent_count - 1)];
		return pick_value();
	endfunction

	// One transfer on the input channel. Called at a rising edge; returns at the
	// edge where the transfer happened with in_valid still high, so a follow-up
	// call in the same step can keep it high without a glitch.
	task automatic send_op(input logic [2:0] act, input logic [31:0] val = '0);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		item_value <= val;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_queue_op(act, val));
		n_sent++;
	endtask

	// Drop valid and hold off until every outstanding result has been seen.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Empty-queue failures, unused codes, field extremes, walk off the end, remove.
	task automatic test_corner_cases();
		send_op(ACT_DEQUEUE);                 // empty pop
		send_op(ACT_NEXT);                    // walk on empty queue
		send_op(ACT_REMOVE);                  // nothing returned yet
		send_op(ACT_REWIND);                  // rewind on empty: cursor stays none
		send_op(ACT_SEARCH, 32'h0);           // search on empty
		send_op(ACT_SPARE_LO, 32'hFFFF_FFFF); // ignored codes
		send_op(ACT_SPARE_HI, 32'h0);
		send_op(ACT_ENQUEUE, 32'h0);          // cursor lands on the new head
		send_op(ACT_ENQUEUE, 32'hFFFF_FFFF);
		send_op(ACT_ENQUEUE, 32'h5A5A_A5A5);
		send_op(ACT_SEARCH, 32'hFFFF_FFFF);   // hit
		send_op(ACT_SEARCH, 32'h1234_5678);   // miss
		send_op(ACT_NEXT);
		send_op(ACT_NEXT);
		send_op(ACT_REMOVE);                  // middle entry, gap closes
		send_op(ACT_REMOVE);                  // mark was cleared by the removal
		send_op(ACT_NEXT);                    // cursor none: end of walk
		send_op(ACT_REWIND);
		send_op(ACT_NEXT);
		send_op(ACT_NEXT);                    // last entry: cursor goes none
		send_op(ACT_NEXT);                    // end of walk, saved cursor is none
		send_op(ACT_REMOVE);                  // remove the tail entry
		send_op(ACT_DEQUEUE);
		send_op(ACT_DEQUEUE);                 // empty again
	endtask

	// Fill to capacity, overflow, full walk, then drain with a sender pause midway.
	task automatic test_fill_and_drain();
		send_op(ACT_REWIND);
		repeat (DEPTH) send_op(ACT_ENQUEUE, pick_value());
		send_op(ACT_ENQUEUE, pick_value());   // full: refused
		send_op(ACT_SEARCH, pick_key());
		send_op(ACT_REWIND);
		repeat (DEPTH + 1) send_op(ACT_NEXT);
		send_op(ACT_REWIND);
		repeat (DEPTH / 2) send_op(ACT_DEQUEUE);
		wait_drained();
		repeat (DEPTH / 2 + 1) send_op(ACT_DEQUEUE);
	endtask

	// A walk: rewind (saving the cursor), step some entries, maybe remove, step on.
	task automatic walk_burst();
		int steps;
		send_op(ACT_REWIND);
		steps = $urandom_range(0, ent_count + 1);
		repeat (steps) send_op(ACT_NEXT);
		if ($urandom_range(0, 2) != 0)
			send_op(ACT_REMOVE);
		repeat ($urandom_range(0, 4)) send_op(ACT_NEXT);
	endtask

	// Weighted random traffic; the enqueue weight drifts so the fill level swings
	// between empty and full. Some stretches run with no idling on either side.
	task automatic test_random_traffic(input int n_ops);
		int stop_at;
		int enq_weight;
		int blk;
		int r;
		stop_at = n_sent + n_ops;
		blk = 0;
		enq_weight = 30;
		while (n_sent < stop_at) begin
			if (blk % 60 == 0) begin
				enq_weight = $urandom_range(15, 50);
				idle_off = ($urandom_range(0, 4) == 0);
			end
			if (blk % 250 == 125)
				wait_drained();
			blk++;
			if ($urandom_range(0, 99) < 8) begin
				walk_burst();
			end else if ($urandom_range(0, 99) < enq_weight) begin
				send_op(ACT_ENQUEUE, pick_value());
			end else begin
				r = $urandom_range(0, 99);
				if (r < 22)
					send_op(ACT_DEQUEUE, $urandom);
				else if (r < 44)
					send_op(ACT_SEARCH, pick_key());
				else if (r < 56)
					send_op(ACT_REWIND, $urandom);
				else if (r < 84)
					send_op(ACT_NEXT, $urandom);
				else if (r < 97)
					send_op(ACT_REMOVE, $urandom);
				else
					send_op($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO, $urandom);
			end
		end
		idle_off = 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Result checking and output-side stalls
	// ---------------------------------------------------------------------

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// Values read right after the edge are the pre-edge ones: the block's and
	// the driver's updates land in the NBA region of this step.
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with none pending, expected nothing, actual ok=%0b item=%0h",
					$time, ok, item_out);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("ok", want.ok, ok);
				check_field("item_out", want.item, item_out);
				check_field("fill_count", want.fill, fill_count);
				check_field("is_empty", want.empty, is_empty);
				n_checked++;
			end
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		action     = ACT_ENQUEUE;
		item_value = '0;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_full_refused = 0;
		n_search_hits = 0;
		n_removed = 0;
		n_walk_end = 0;
		idle_off = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		ent_count  = '0;
		walk_pos   = MARK_NONE;
		walk_saved = MARK_NONE;
		last_taken = MARK_NONE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_fill_and_drain();
		test_random_traffic(840);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d operations and %0d checked results, including %0d refused enqueues,",
			n_sent, n_checked, n_full_refused);
		$display("%0d search hits, %0d removals and %0d walks past the end.",
			n_search_hits, n_removed, n_walk_end);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
